// File: design/bsoc_pkg.sv
// shared types and constants for the battery charge led indicator
// no dependencies; imported by bsoc_step and battery_soc_led_indicator_top
`default_nettype none

package bsoc_pkg;

   // item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   // frame identifiers
   localparam logic [28:0] ID_FAULT_WORD = 29'h1F11FA01;
   localparam logic [28:0] ID_CHARGE     = 29'h1F10FA01;
   localparam logic [28:0] ID_FAULT_BYTE = 29'h000001AA;
   localparam logic [28:0] ID_BATTERY    = 29'h000002AA;
   localparam logic [28:0] ID_CURRENT    = 29'h000003AA;

   // charge bands
   localparam logic [7:0] BAND_ONE   = 8'd25;
   localparam logic [7:0] BAND_TWO   = 8'd50;
   localparam logic [7:0] BAND_THREE = 8'd75;
   localparam logic [7:0] BAND_FULL  = 8'd100;

   // csr register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_TICKS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP_END    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COMM_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OC_LIMIT     = 3'd5;

   // csr reset values
   localparam logic [15:0] RST_SLOT_TICKS   = 16'd500;
   localparam logic [15:0] RST_CYCLE_TOP    = 16'd250;
   localparam logic [15:0] RST_SLEEP_START  = 16'd120;
   localparam logic [15:0] RST_SLEEP_END    = 16'd240;
   localparam logic [7:0]  RST_COMM_TIMEOUT = 8'd5;
   localparam logic [15:0] RST_OC_LIMIT     = 16'd200;

   typedef struct packed {
      logic        kind;
      logic [28:0] frame_id;
      logic [63:0] frame_data;
   } req_type;

   typedef struct packed {
      logic [3:0] bar_leds;
      logic       fault_lamp;
      logic       fault_blink_lamp;
      logic       sleeping;
      logic       link_failed;
      logic [7:0] fault_flags_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] slot_ticks;
      logic [15:0] cycle_top;
      logic [15:0] sleep_start;
      logic [15:0] sleep_end;
      logic [7:0]  comm_timeout;
      logic [15:0] over_current_limit;
   } cfg_type;

   typedef struct packed {
      logic       steady;
      logic       blink;
      logic [3:0] bars;
   } lamp_type;

   typedef struct packed {
      logic [15:0] tick_count;
      logic [1:0]  blink_phase;
      logic [15:0] cycle_count;
      logic [7:0]  silence_count;
      logic        link_fail_flag;
      logic        sleep_flag;
      logic [7:0]  charge_level;
      logic [31:0] fault_word;
      logic        over_current_flag;
      logic [7:0]  fault_flags;
      lamp_type    lamp_state;
   } state_type;

endpackage

`default_nettype wire

// File: design/bsoc_step.sv
// next-state and lamp logic for one word (tick or frame)
// depends on bsoc_pkg
`default_nettype none

module bsoc_step
   import bsoc_pkg::*;
(
   input  wire state_type cur_state,
   input  wire cfg_type   cfg,
   input  wire req_type   item,
   output state_type      nxt_state,
   output rsp_type        result
);

   logic [15:0] tick_inc;
   logic [15:0] cycle_inc;
   logic [1:0]  blink_inc;
   logic [7:0]  silence_inc;
   logic [7:0]  fault_byte;
   logic [15:0] current;
   logic        ok;
   logic        on;
   logic        awake;
   state_type   s;
   lamp_type    lamp;

   assign tick_inc    = cur_state.tick_count + 16'd1;
   assign cycle_inc   = cur_state.cycle_count + 16'd1;
   assign blink_inc   = cur_state.blink_phase + 2'd1;
   assign silence_inc = (cur_state.silence_count != 8'hFF) ?
                        cur_state.silence_count + 8'd1 : cur_state.silence_count;
   assign fault_byte  = item.frame_data[47:40];
   assign current     = {item.frame_data[7:0], item.frame_data[15:8]};

   always_comb begin
      s = cur_state;
      if (item.kind == KIND_TICK) begin
         s.tick_count = tick_inc;
         if (tick_inc > cfg.slot_ticks) begin
            // slot boundary
            s.tick_count    = 16'd1;
            s.blink_phase   = (blink_inc > 2'd2) ? 2'd0 : blink_inc;
            s.cycle_count   = (cycle_inc > cfg.cycle_top) ? 16'd0 : cycle_inc;
            s.silence_count = silence_inc;
            if (silence_inc > cfg.comm_timeout) begin
               s.link_fail_flag = 1'b1;
            end
            if (s.cycle_count < cfg.sleep_start) begin
               s.sleep_flag = 1'b0;
            end
            if (s.cycle_count >= cfg.sleep_start && s.cycle_count < cfg.sleep_end) begin
               s.sleep_flag = 1'b1;
            end
         end
      end else begin
         case (item.frame_id)
            ID_FAULT_WORD: begin
               s.fault_word = item.frame_data[31:0];
            end
            ID_CHARGE: begin
               s.charge_level   = item.frame_data[7:0];
               s.link_fail_flag = 1'b0;
            end
            ID_FAULT_BYTE: begin
               s.fault_word     = {24'd0, fault_byte};
               // sticky flag for the lowest set fault bit
               s.fault_flags    = cur_state.fault_flags | (fault_byte & (~fault_byte + 8'd1));
               s.silence_count  = 8'd0;
               s.link_fail_flag = 1'b0;
            end
            ID_BATTERY: begin
               s.charge_level   = item.frame_data[7:0];
               s.silence_count  = 8'd0;
               s.link_fail_flag = 1'b0;
            end
            ID_CURRENT: begin
               s.over_current_flag = (current >= cfg.over_current_limit);
               s.silence_count     = 8'd0;
               s.link_fail_flag    = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // lamps from the updated state
      ok    = (s.fault_word == 32'd0) && !s.over_current_flag;
      on    = (s.blink_phase > 2'd1);
      awake = !s.sleep_flag;
      lamp  = cur_state.lamp_state;
      if (!awake) begin
         lamp.bars = 4'd0;
      end
      if (ok && s.charge_level <= BAND_ONE) begin
         lamp.bars   = awake ? {3'b000, on} : 4'd0;
         lamp.blink  = 1'b0;
         lamp.steady = 1'b0;
      end else if (ok && s.charge_level <= BAND_TWO) begin
         lamp.bars   = awake ? {2'b00, on, 1'b1} : 4'd0;
         lamp.blink  = 1'b0;
         lamp.steady = 1'b0;
      end else if (ok && s.charge_level <= BAND_THREE) begin
         lamp.bars   = awake ? {1'b0, on, 2'b11} : 4'd0;
         lamp.blink  = 1'b0;
         lamp.steady = 1'b0;
      end else if (ok && s.charge_level <= BAND_FULL) begin
         lamp.bars   = awake ? {on, 3'b111} : 4'd0;
         lamp.blink  = 1'b0;
         lamp.steady = 1'b0;
      end else if (!ok) begin
         lamp.bars   = 4'd0;
         lamp.steady = 1'b1;
         lamp.blink  = (s.blink_phase == 2'd1);
      end
      s.lamp_state = lamp;
      nxt_state    = s;

      result.bar_leds         = lamp.bars;
      result.fault_lamp       = lamp.steady;
      result.fault_blink_lamp = lamp.blink;
      result.sleeping         = s.sleep_flag;
      result.link_failed      = s.link_fail_flag;
      result.fault_flags_out  = s.fault_flags;
   end

endmodule

`default_nettype wire

// File: design/battery_soc_led_indicator_top.sv
// top level of the battery charge led indicator: input register, state, result register
// depends on bsoc_pkg and bsoc_step
`default_nettype none

// usage
// - req channel: one word per timer tick (kind 0) or received status frame (kind 1),
//   valid/ready handshake; frame_id and frame_data are ignored for ticks
// - rsp channel: exactly one result word per request word, in order: bar lamps,
//   steady and blinking fault lamps, sleep and link failure flags, sticky fault flags
// - csr channel: register index and write data, always ready; write only while idle
// - a word accepted from req is latched in the input register; when the result slot
//   is free the state updates and the result register loads, and rsp_valid rises
//   as the result register loads; the result is held there until the receiver takes it
// - throughput is one word per cycle unless the receiver stalls: the whole update is
//   one pass of compare and increment logic between the input and result registers
// - when the receiver stalls, the result register holds and the input register
//   keeps one more word; req_ready drops only while both are full
// - reset (synchronous) clears all counters, flags and lamps, drops both valids
//   and restores the csr defaults (slot 500 ticks, cycle top 250, sleep 120..240,
//   timeout 5 slots, over-current limit 200)

module battery_soc_led_indicator_top
   import bsoc_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire req_type         req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rsp_type              rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [15:0]           csr_data
);

   // input register
   logic      req_valid_ff;
   logic      req_valid_in;
   req_type   req_ff;
   // block state and csrs
   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   // result register
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;

   logic      advance;

   // word moves from input register into state/result when result slot frees
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   bsoc_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .item      (req_ff),
      .nxt_state (state_in),
      .result    (rsp_in)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLOT_TICKS:   cfg_in.slot_ticks         = csr_data;
            CSR_CYCLE_TOP:    cfg_in.cycle_top          = csr_data;
            CSR_SLEEP_START:  cfg_in.sleep_start        = csr_data;
            CSR_SLEEP_END:    cfg_in.sleep_end          = csr_data;
            CSR_COMM_TIMEOUT: cfg_in.comm_timeout       = csr_data[7:0];
            CSR_OC_LIMIT:     cfg_in.over_current_limit = csr_data;
            default: begin
            end
         endcase
      end
   end

   // control, state and csrs
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff.slot_ticks         <= RST_SLOT_TICKS;
         cfg_ff.cycle_top          <= RST_CYCLE_TOP;
         cfg_ff.sleep_start        <= RST_SLEEP_START;
         cfg_ff.sleep_end          <= RST_SLEEP_END;
         cfg_ff.comm_timeout       <= RST_COMM_TIMEOUT;
         cfg_ff.over_current_limit <= RST_OC_LIMIT;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // a held input word is never dropped while the result slot is busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff)
      else $error("input word lost while stalled");

   // blink phase counts 0,1,2 only
   assert property (@(posedge clock) disable iff (reset)
      state_ff.blink_phase != 2'd3)
      else $error("blink phase out of range");

   // steady fault lamp always goes with dark bars
   assert property (@(posedge clock) disable iff (reset)
      state_ff.lamp_state.steady |-> state_ff.lamp_state.bars == 4'd0)
      else $error("bars lit with steady fault lamp");

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
